/* src/nlpc_pkg.sv */
// ----------------------------------------------------------------------------
// nlpc_pkg
// shared types, codes and sizes of the nearest leader clustering unit
// ----------------------------------------------------------------------------
package nlpc_pkg;

  localparam int MAX_CLUSTERS = 128;
  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CW = $clog2(MAX_CLUSTERS + 1);

  localparam int IN_DW  = 136;
  localparam int OUT_DW = 144;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // request codes (decoder looks at bit 1 for reads)
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_CREATED = 3'd0;
  localparam logic [2:0] STAT_MERGED  = 3'd1;
  localparam logic [2:0] STAT_CULLED  = 3'd2;
  localparam logic [2:0] STAT_CLEARED = 3'd3;
  localparam logic [2:0] STAT_READ_OK = 3'd4;
  localparam logic [2:0] STAT_EMPTY   = 3'd5;

  localparam logic [9:0] MEMBERS_MAX = 10'h3FF;

  typedef struct packed {
    logic [9:0]         members;
    logic [12:0]        effect;
    logic [2:0]         kind;
    logic [11:0]        weight;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [23:0] z;
    logic signed [23:0] y;
    logic signed [23:0] x;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_issue;
    logic read_issue;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_done;
    logic pipe_busy;
    logic out_busy;
  } sts_t;

endpackage

/* src/nearest_leader_point_clustering_unit.sv */
// ----------------------------------------------------------------------------
// nearest_leader_point_clustering_unit
// groups weighted 3d points into clusters around their nearest leader
// ----------------------------------------------------------------------------
// add: accept, a scan of the N stored clusters, a drain of the distance pipe
//   and a finish; N = clusters stored, so up to 128; the scan goes through the
//   one read port of the slot ram, one slot compared per cycle
// read and clear: one item at a time, next accepted on the
//   cycle after the result is formed even while that result is still held
// reset: async active low, table empties and radius goes to zero, no sweep
module nearest_leader_point_clustering_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config: merge radius, eighth units
  input  logic         cfg_we_i,
  input  logic [22:0]  cfg_wdata_i,
  // in tdata: pos_x[23:0] pos_y[47:24] pos_z[71:48] red[79:72] green[87:80]
  //   blue[95:88] weight[107:96] kind[110:108] effect_id[123:111]
  //   read_index[130:124], zero pad
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,   // req_type
  // out tdata: cluster_index[6:0] cluster_total[14:7] member_count[24:15]
  //   rep_x[48:25] rep_y[72:49] rep_z[96:73] rep_red[104:97]
  //   rep_green[112:105] rep_blue[120:113] rep_kind[123:121]
  //   rep_effect[136:124], zero pad
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [143:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // status
);
  import nlpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: walks accept, scan, drain, read and finish
  nlpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath: slot ram, distance pipe and result register
  nlpc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata_i),
    .in_req_i     (s_axis_tuser_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

/* src/nlpc_ram.sv */
// ----------------------------------------------------------------------------
// nlpc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nlpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/nlpc_ctrl.sv */
// ----------------------------------------------------------------------------
// nlpc_ctrl
// sequencer: accept, scan the table or read a slot, drain the distance pipe, finish
// ----------------------------------------------------------------------------
module nlpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_req_i,
  output logic          in_ready_o,
  output nlpc_pkg::cmd_t cmd_o,
  input  nlpc_pkg::sts_t sts_i
);
  import nlpc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_req_i == REQ_CLEAR) begin
            state_d = S_FIN;
          end else if (in_req_i[1]) begin
            state_d = S_READ;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.issue_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_FIN;
        end
      end
      S_READ: begin
        cmd_o.read_issue = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/nlpc_datapath.sv */
// ----------------------------------------------------------------------------
// nlpc_datapath
// slot table, distance pipe, nearest tracking, write back and result register
// ----------------------------------------------------------------------------
module nlpc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nlpc_pkg::cmd_t               cmd_i,
  output nlpc_pkg::sts_t               sts_o,
  input  logic [nlpc_pkg::IN_DW-1:0]   in_data_i,
  input  logic [1:0]                   in_req_i,
  input  logic                         cfg_we_i,
  input  logic [22:0]                  cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [nlpc_pkg::OUT_DW-1:0]  out_data_o,
  output logic [2:0]                   out_status_o
);
  import nlpc_pkg::*;

  // captured request
  logic [1:0]  req_q;
  entry_t      cand_q;
  logic [6:0]  ridx_q;

  logic [22:0] radius_q;
  logic [45:0] rsq_q;
  cnt_t        count_q, count_d;
  cnt_t        scan_q;

  // ram
  logic   ram_re, ram_we;
  addr_t  ram_raddr, ram_waddr;
  entry_t ram_wdata, ram_rdata;

  // distance pipe
  logic        p1_v_q, p2_v_q;
  addr_t       p1_idx_q, p2_idx_q;
  entry_t      p2_e_q;
  logic [48:0] sqx_q, sqy_q, sqz_q;

  // nearest so far
  logic        found_q;
  logic [50:0] best_q;
  addr_t       tgt_q;
  entry_t      best_e_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [OUT_DW-1:0] out_data_q;

  assign ram_re    = cmd_i.scan_issue | cmd_i.read_issue;
  assign ram_raddr = cmd_i.read_issue ? addr_t'(ridx_q) : scan_q[AW-1:0];

  nlpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_CLUSTERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.issue_done = (scan_q >= count_q);
  assign sts_o.pipe_busy  = p1_v_q | p2_v_q;
  assign sts_o.out_busy   = out_valid_q;

  // stage 1: differences and squares
  logic signed [24:0] dx, dy, dz;
  logic signed [49:0] px, py, pz;
  assign dx = {cand_q.x[23], cand_q.x} - {ram_rdata.x[23], ram_rdata.x};
  assign dy = {cand_q.y[23], cand_q.y} - {ram_rdata.y[23], ram_rdata.y};
  assign dz = {cand_q.z[23], cand_q.z} - {ram_rdata.z[23], ram_rdata.z};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // stage 2: sum and compare, ties go to the later slot
  logic [50:0] d2, thr;
  logic        hit;
  assign d2  = 51'(sqx_q) + 51'(sqy_q) + 51'(sqz_q);
  assign thr = found_q ? best_q : 51'(rsq_q);
  assign hit = p2_v_q && (d2 <= thr);

  // finish: write back and result
  entry_t new_e, mrg_e, res_e;
  logic   res_full;
  logic [2:0] res_status;
  addr_t  res_idx;
  logic [6:0] res_idx7;
  logic   rd_ok;
  logic [7:0] total;

  always_comb begin
    new_e         = cand_q;
    new_e.members = 10'd1;
    if (cand_q.weight > best_e_q.weight) begin
      mrg_e         = cand_q;
    end else begin
      mrg_e         = best_e_q;
    end
    mrg_e.members = (best_e_q.members == MEMBERS_MAX) ? best_e_q.members
                                                      : best_e_q.members + 10'd1;
    rd_ok = (32'(ridx_q) < 32'(count_q)) && (32'(ridx_q) < MAX_CLUSTERS);

    count_d    = count_q;
    ram_we     = 1'b0;
    ram_waddr  = tgt_q;
    ram_wdata  = mrg_e;
    res_e      = mrg_e;
    res_full   = 1'b1;
    res_status = STAT_MERGED;
    res_idx    = tgt_q;
    res_idx7   = 7'(tgt_q);

    if (req_q == REQ_CLEAR) begin
      count_d    = '0;
      res_status = STAT_CLEARED;
      res_full   = 1'b0;
      res_idx7   = 7'd0;
    end else if (req_q[1]) begin
      res_e    = ram_rdata;
      res_idx7 = ridx_q;
      if (rd_ok) begin
        res_status = STAT_READ_OK;
      end else begin
        res_status = STAT_EMPTY;
        res_full   = 1'b0;
      end
    end else if (!found_q) begin
      if (32'(count_q) >= MAX_CLUSTERS) begin
        res_status = STAT_CULLED;
        res_full   = 1'b0;
        res_idx7   = 7'd0;
      end else begin
        res_idx    = count_q[AW-1:0];
        res_idx7   = 7'(res_idx);
        ram_we     = cmd_i.finish;
        ram_waddr  = res_idx;
        ram_wdata  = new_e;
        res_e      = new_e;
        res_status = STAT_CREATED;
        count_d    = cnt_t'(count_q + 1'b1);
      end
    end else begin
      ram_we = cmd_i.finish;
    end

    total = (32'(count_d) > 255) ? 8'd255 : 8'(count_d);
    if (!res_full) begin
      res_e = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q        <= in_req_i;
      cand_q.x     <= in_data_i[23:0];
      cand_q.y     <= in_data_i[47:24];
      cand_q.z     <= in_data_i[71:48];
      cand_q.red   <= in_data_i[79:72];
      cand_q.green <= in_data_i[87:80];
      cand_q.blue  <= in_data_i[95:88];
      cand_q.weight  <= in_data_i[107:96];
      cand_q.kind    <= in_data_i[110:108];
      cand_q.effect  <= in_data_i[123:111];
      cand_q.members <= '0;
      ridx_q       <= in_data_i[130:124];
    end
    rsq_q    <= radius_q * radius_q;
    p1_idx_q <= scan_q[AW-1:0];
    p2_idx_q <= p1_idx_q;
    p2_e_q   <= ram_rdata;
    sqx_q    <= px[48:0];
    sqy_q    <= py[48:0];
    sqz_q    <= pz[48:0];
    if (hit) begin
      best_q   <= d2;
      tgt_q    <= p2_idx_q;
      best_e_q <= p2_e_q;
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_data_q   <= {7'd0, res_e.effect, res_e.kind, res_e.blue, res_e.green,
                       res_e.red, res_e.z, res_e.y, res_e.x, res_e.members,
                       total, res_idx7};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      p1_v_q <= cmd_i.scan_issue;
      p2_v_q <= p1_v_q;
      if (cmd_i.capture) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_q <= cnt_t'(scan_q + 1'b1);
        end
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

/* src/nlpc_checker.sv */
// ----------------------------------------------------------------------------
// nlpc_checker
// port level checks of the clustering unit, bound to the top level
// ----------------------------------------------------------------------------
module nlpc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [143:0] m_axis_tdata_o,
  input logic [2:0]   m_axis_tuser_o
);
  import nlpc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result shown during reset");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_CLEARED |-> m_axis_tdata_o == '0)
    else $error("clear result not all zero");

  a_cull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_CULLED
      |-> 32'(m_axis_tdata_o[14:7]) == ((MAX_CLUSTERS > 255) ? 255 : MAX_CLUSTERS))
    else $error("cull with table not full");

  a_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_CREATED && MAX_CLUSTERS <= 128
      |-> 8'(m_axis_tdata_o[6:0]) + 8'd1 == m_axis_tdata_o[14:7])
    else $error("new cluster not at end of table");

endmodule

bind nearest_leader_point_clustering_unit nlpc_checker u_nlpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/nlpc_checker.sv */
// ----------------------------------------------------------------------------
// nlpc_scoreboard
// watches the config, input and result channels of the clustering unit,
// keeps its own cluster table and compares every result with the prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nlpc_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [22:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [135:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [143:0] m_axis_tdata_i,
  input  logic [2:0]   m_axis_tuser_i,
  output int           errors_o,
  output int           pending_o
);
  import nlpc_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         idx;
    logic [7:0]         total;
    logic [9:0]         members;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [2:0]         kind;
    logic [12:0]        eff;
  } cluster_res_t;

  logic [22:0]  radius;
  entry_t       table_q [MAX_CLUSTERS];
  int           used;
  cluster_res_t awaited_q[$];

  function automatic longint unsigned sq_diff(logic signed [23:0] a,
                                              logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  function automatic cluster_res_t slot_result(logic [2:0] st, int s);
    cluster_res_t r;
    r = '0;
    r.status  = st;
    r.idx     = s[6:0];
    r.total   = used[7:0];
    r.members = table_q[s].members;
    r.x = table_q[s].x;  r.y = table_q[s].y;  r.z = table_q[s].z;
    r.r = table_q[s].red;  r.g = table_q[s].green;  r.b = table_q[s].blue;
    r.kind = table_q[s].kind;
    r.eff  = table_q[s].effect;
    return r;
  endfunction

  // new representative taken from the candidate, member count kept
  function automatic entry_t adopt(entry_t old, logic [135:0] d);
    entry_t e;
    e        = old;
    e.x      = d[23:0];
    e.y      = d[47:24];
    e.z      = d[71:48];
    e.red    = d[79:72];
    e.green  = d[87:80];
    e.blue   = d[95:88];
    e.weight = d[107:96];
    e.kind   = d[110:108];
    e.effect = d[123:111];
    return e;
  endfunction

  function automatic cluster_res_t cluster_step(logic [1:0] req, logic [135:0] d);
    cluster_res_t     r;
    longint unsigned  best, d2;
    logic             hit;
    int               tgt, ri;
    r = '0;
    if (req == REQ_CLEAR) begin
      used = 0;
      r.status = STAT_CLEARED;
      return r;
    end
    // bit 1 alone selects a read, so code three reads too
    if (req[1]) begin
      ri = int'(d[130:124]);
      if (ri < used) return slot_result(STAT_READ_OK, ri);
      r.status = STAT_EMPTY;
      r.idx    = d[130:124];
      r.total  = used[7:0];
      return r;
    end
    best = longint'(radius) * longint'(radius);
    hit  = 1'b0;
    tgt  = 0;
    for (int j = 0; j < used; j++) begin
      d2 = sq_diff(d[23:0], table_q[j].x) + sq_diff(d[47:24], table_q[j].y) +
           sq_diff(d[71:48], table_q[j].z);
      // <= lets the later slot win a tie
      if (d2 <= best) begin
        best = d2;
        tgt  = j;
        hit  = 1'b1;
      end
    end
    if (!hit) begin
      if (used >= MAX_CLUSTERS) begin
        r.status = STAT_CULLED;
        r.total  = used[7:0];
        return r;
      end
      table_q[used] = adopt('0, d);
      table_q[used].members = 10'd1;
      used++;
      return slot_result(STAT_CREATED, used - 1);
    end
    if (table_q[tgt].members != MEMBERS_MAX) table_q[tgt].members++;
    if (d[107:96] > table_q[tgt].weight) table_q[tgt] = adopt(table_q[tgt], d);
    return slot_result(STAT_MERGED, tgt);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cluster_res_t got, want;
    if (!rst_ni) begin
      radius = '0;
      used   = 0;
      awaited_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // results first: a result never belongs to an item taken on the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '0;
        got.status  = m_axis_tuser_i;
        got.idx     = m_axis_tdata_i[6:0];
        got.total   = m_axis_tdata_i[14:7];
        got.members = m_axis_tdata_i[24:15];
        got.x       = m_axis_tdata_i[48:25];
        got.y       = m_axis_tdata_i[72:49];
        got.z       = m_axis_tdata_i[96:73];
        got.r       = m_axis_tdata_i[104:97];
        got.g       = m_axis_tdata_i[112:105];
        got.b       = m_axis_tdata_i[120:113];
        got.kind    = m_axis_tdata_i[123:121];
        got.eff     = m_axis_tdata_i[136:124];
        if (awaited_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("%0t: result with nothing awaited: %p", $realtime, got);
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        awaited_q = {awaited_q, cluster_step(s_axis_tuser_i, s_axis_tdata_i)};
      if (cfg_we_i) radius = cfg_wdata_i;
      pending_o = awaited_q.size();
    end
  end

endmodule

/* tb/tb_nearest_leader_point_clustering_unit.sv */
// ----------------------------------------------------------------------------
// tb_nearest_leader_point_clustering_unit
// drives clear, add and read items in bursts through phases of merge radius,
// with a stalling receiver; the scoreboard predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_nearest_leader_point_clustering_unit;
  import nlpc_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [22:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = REQ_CLEAR;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  int           errors, pending;

  // recent candidate positions, reused to land exactly on stored leaders
  logic [71:0]  seen_pos[$];
  logic [71:0]  first_pos;
  int           burst_left;

  always #6 clk_i = ~clk_i;

  nearest_leader_point_clustering_unit dut (.*);

  nlpc_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: stall pattern steps through four modes, chosen from the simulation time
  always @(posedge clk_i) begin
    int unsigned mode;
    mode = int'($realtime) / 12 / 256;
    case (mode % 4)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 1) == 1);
      2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one item: held until taken, then a gap between bursts or straight on
  task automatic send_item(logic [1:0] req, logic [71:0] pos, logic [23:0] rgb,
                           logic [11:0] wgt, logic [2:0] knd, logic [12:0] eff,
                           logic [6:0] ri);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {5'b0, ri, eff, knd, wgt, rgb[7:0], rgb[15:8], rgb[23:16], pos};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    @(posedge clk_i);
    if (req == REQ_ADD) begin
      seen_pos = {seen_pos, pos};
      if (seen_pos.size() > 48) void'(seen_pos.pop_front());
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [71:0] rand_pos();
    return {24'($urandom), 24'($urandom), 24'($urandom)};
  endfunction

  task automatic add_at(logic [71:0] pos, logic [11:0] wgt);
    send_item(REQ_ADD, pos, 24'($urandom), wgt, 3'($urandom), 13'($urandom),
              7'($urandom));
  endtask

  task automatic read_slot(logic [6:0] ri, logic [1:0] code);
    send_item(code, rand_pos(), 24'($urandom), 12'($urandom), 3'($urandom),
              13'($urandom), ri);
  endtask

  // wait for every result, then write the radius while the unit is idle
  task automatic drain_and_set_radius(logic [22:0] rad);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rad;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [71:0] near_pos(int spread);
    logic [71:0] p;
    p[23:0]  = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p[47:24] = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p[71:48] = 24'($signed($urandom_range(0, 2 * spread)) - spread);
    return p;
  endfunction

  // random item: a clear, a read or an add at a stored position, close by or anywhere
  task automatic random_item(int spread);
    int pick;
    logic [71:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 6)
      send_item(REQ_CLEAR, rand_pos(), 24'($urandom), 12'($urandom),
                3'($urandom), 13'($urandom), 7'($urandom));
    else if (pick < 20)
      read_slot(7'($urandom), ($urandom_range(0, 3) == 0) ? 2'd3 : REQ_READ);
    else begin
      if (pick < 45 && seen_pos.size() > 0)
        p = seen_pos[$urandom_range(0, seen_pos.size() - 1)];
      else if (spread == 0)
        p = rand_pos();
      else
        p = near_pos(spread);
      add_at(p, 12'($urandom));
    end
  endtask

  initial begin
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, every request code, replace rules, ties, culling
    send_item(REQ_CLEAR, '1, '1, '1, '1, '1, '1);
    read_slot(7'd0, REQ_READ);
    read_slot(7'd127, 2'd3);
    add_at({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 12'hFFF);
    add_at({24'h800000, 24'h800000, 24'h800000}, 12'h000);
    add_at({24'h800000, 24'h800000, 24'h800000}, 12'h000);  // equal weight keeps
    add_at({24'h800000, 24'h800000, 24'h800000}, 12'h001);  // heavier replaces
    add_at({24'h800000, 24'h800000, 24'h800000}, 12'h000);  // lighter keeps
    add_at({24'h000000, 24'h000000, 24'h000001}, 12'h800);  // zero radius: no merge
    read_slot(7'd1, REQ_READ);
    read_slot(7'd3, REQ_READ);
    drain_and_set_radius(23'd10);
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    add_at({24'd0, 24'd0, 24'd0}, 12'd5);
    add_at({24'd0, 24'd0, 24'd20}, 12'd5);
    add_at({24'd0, 24'd0, 24'd10}, 12'd9);   // tie: later slot wins
    add_at({24'd0, 24'd0, 24'd31}, 12'd9);   // outside the radius
    drain_and_set_radius(23'h7FFFFF);
    add_at({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 12'hFFF);
    read_slot(7'd2, REQ_READ);

    // fill the table with zero radius, cull, then pile onto the first leader
    // until its member count saturates
    drain_and_set_radius(23'd0);
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    first_pos = rand_pos();
    add_at(first_pos, 12'h000);
    for (int i = 0; i < 129; i++) add_at(rand_pos(), 12'($urandom));
    for (int i = 0; i < 1030; i++) begin
      if (i % 200 == 199) read_slot(7'd0, REQ_READ);
      else add_at(first_pos, 12'($urandom));
    end
    read_slot(7'd0, REQ_READ);
    for (int i = 0; i < 10; i++) random_item(0);

    // mid radii with clustered positions
    drain_and_set_radius(23'($urandom_range(1, 4000)));
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    seen_pos.delete();
    for (int i = 0; i < 20; i++) random_item(20000);
    drain_and_set_radius(23'($urandom_range(4001, 8388606)));
    for (int i = 0; i < 10; i++) random_item(8388607);

    // widest radius: everything lands on one leader
    drain_and_set_radius(23'h7FFFFF);
    send_item(REQ_CLEAR, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 5; i++) add_at(near_pos(1000000), 12'($urandom));
    read_slot(7'd0, REQ_READ);

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
src/nlpc_pkg.sv
src/nlpc_ram.sv
src/nlpc_ctrl.sv
src/nlpc_datapath.sv
src/nearest_leader_point_clustering_unit.sv
src/nlpc_checker.sv
tb/nlpc_checker.sv
tb/tb_nearest_leader_point_clustering_unit.sv
